@@ design/mcd_pkg.sv @@
`default_nettype none

package mcd_pkg;

  // Default sizes of the correlator
  localparam int MAX_SYMBOLS_DEF    = 16;
  localparam int COS_TABLE_BITS_DEF = 10;
  localparam int SUM_BITS_DEF       = 48;

  // Fixed field widths
  localparam int SAMPLE_BITS = 16;
  localparam int COS_BITS    = 16;
  localparam int PROD_BITS   = SAMPLE_BITS + COS_BITS;
  localparam int PHASE_BITS  = 32;
  localparam int SYMBOL_W    = 4;
  localparam int SYM_BITS_W  = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_INDEX_W = 1;

  // pi/2 in Q30
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_PHASE_STEP  = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SYMBOL_BITS = 1'd1;

  typedef enum logic {
    ST_RUN,
    ST_SCAN
  } mcd_state_t;

  // Control shared by all correlator cells
  typedef struct packed {
    logic                  mul_en;
    logic                  acc_en;
    logic                  scan_en;
    logic                  clear;
    logic [SYM_BITS_W-1:0] eff_bits;
  } cell_ctrl_t;

  // Magnitude of cos(r * (pi/2) / Q) in Q1.15, Q = 2^(table_bits-2), 0 <= r <= Q.
  // Taylor series in Q30 with truncating steps, then round half up.
  function automatic logic [COS_BITS-2:0] cos_quarter_mag(input int unsigned r,
                                                          input int unsigned table_bits);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic [63:0]        mag;
    logic signed [63:0] sum;
    logic signed [63:0] v;
    int                 k;
    x    = (HALF_PI_Q30 * 64'(r)) >> (table_bits - 2);
    x2   = (x * x) >> 30;
    term = 64'd1 << 30;
    sum  = $signed(term);
    for (k = 1; k <= 10; k++) begin
      mag  = (term * x2) >> 30;
      mag  = mag / 64'((2 * k - 1) * (2 * k));
      term = mag;
      if (k % 2 == 1) begin
        sum = sum - $signed(term);
      end else begin
        sum = sum + $signed(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    v = (sum + 64'sd16384) >>> 15;
    if (v > 64'sd32767) begin
      v = 64'sd32767;
    end
    return v[COS_BITS-2:0];
  endfunction

endpackage

`default_nettype wire

@@ design/mcd_in_if.sv @@
`default_nettype none

interface mcd_in_if import mcd_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          symbol_strobe;

  modport source (output valid, output sample, output symbol_strobe, input ready);
  modport sink   (input valid, input sample, input symbol_strobe, output ready);
endinterface

`default_nettype wire

@@ design/mcd_out_if.sv @@
`default_nettype none

interface mcd_out_if import mcd_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SYMBOL_W-1:0] symbol;

  modport source (output valid, output symbol, input ready);
  modport sink   (input valid, input symbol, output ready);
endinterface

`default_nettype wire

@@ design/mcd_cell.sv @@
`default_nettype none

// One correlator: cosine lookup and multiply, saturating accumulate, and one
// link of the max-search chain that runs from cell 0 upward.
module mcd_cell import mcd_pkg::*; #(
  parameter int CELL_INDEX     = 0,
  parameter int COS_TABLE_BITS = COS_TABLE_BITS_DEF,
  parameter int SUM_BITS       = SUM_BITS_DEF,
  parameter int IDX_BITS       = 4
) (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire cell_ctrl_t                     ctrl,
  input  wire logic signed [SAMPLE_BITS-1:0]  sample,
  input  wire logic [COS_TABLE_BITS-1:0]      phase_top,
  input  wire logic signed [SUM_BITS-1:0]     prev_val,
  input  wire logic [IDX_BITS-1:0]            prev_idx,
  output logic signed [SUM_BITS-1:0]          best_val,
  output logic [IDX_BITS-1:0]                 best_idx
);

  localparam int QUARTER = 1 << (COS_TABLE_BITS - 2);
  localparam int ADDR_W  = COS_TABLE_BITS - 1;
  localparam logic [COS_TABLE_BITS-1:0] K_TOP = COS_TABLE_BITS'(CELL_INDEX);
  localparam logic [IDX_BITS-1:0]       K_IDX = IDX_BITS'(CELL_INDEX);

  typedef logic [COS_BITS-2:0] rom_t [QUARTER+1];

  function automatic rom_t build_rom();
    rom_t rom;
    for (int i = 0; i <= QUARTER; i++) begin
      rom[i] = cos_quarter_mag(i, COS_TABLE_BITS);
    end
    return rom;
  endfunction

  localparam rom_t ROM = build_rom();

  logic                          active;
  logic [COS_TABLE_BITS-1:0]     tab_idx;
  logic [1:0]                    quad;
  logic [ADDR_W-1:0]             rom_addr;
  logic [COS_BITS-2:0]           cos_mag;
  logic signed [COS_BITS-1:0]    cos_val;
  logic signed [PROD_BITS-1:0]   prod;
  logic signed [SUM_BITS-1:0]    sum;
  logic [SUM_BITS:0]             wide;
  logic signed [SUM_BITS-1:0]    sum_next;

  // Cell takes part only below M = 2^eff_bits
  assign active = ({{(32-SYM_BITS_W){1'b0}}, ctrl.eff_bits} < 32'd32) &&
                  (32'(CELL_INDEX) < (32'd1 << ctrl.eff_bits));

  // Reference phase k/M turn added in the table index domain
  assign tab_idx = phase_top + (K_TOP << (COS_TABLE_BITS - 32'(ctrl.eff_bits)));

  // Quarter-wave lookup
  assign quad     = tab_idx[COS_TABLE_BITS-1 -: 2];
  assign rom_addr = quad[0] ? (ADDR_W'(QUARTER) - ADDR_W'(tab_idx[COS_TABLE_BITS-3:0]))
                            : ADDR_W'(tab_idx[COS_TABLE_BITS-3:0]);
  assign cos_mag  = ROM[rom_addr];
  assign cos_val  = (quad[1] ^ quad[0]) ? -$signed({1'b0, cos_mag}) : $signed({1'b0, cos_mag});

  // Product stage
  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod <= PROD_BITS'(sample) * PROD_BITS'(cos_val);
    end
  end

  // Saturating add
  always_comb begin
    wide = {sum[SUM_BITS-1], sum} + {{(SUM_BITS+1-PROD_BITS){prod[PROD_BITS-1]}}, prod};
    if (wide[SUM_BITS] != wide[SUM_BITS-1]) begin
      sum_next = wide[SUM_BITS] ? $signed({1'b1, {(SUM_BITS-1){1'b0}}})
                                : $signed({1'b0, {(SUM_BITS-1){1'b1}}});
    end else begin
      sum_next = $signed(wide[SUM_BITS-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      sum <= '0;
    end else if (ctrl.acc_en && active) begin
      sum <= sum_next;
    end
  end

  // Max-search link: strictly larger replaces, so lower index wins ties
  always_ff @(posedge clk) begin
    if (ctrl.scan_en) begin
      if (!active) begin
        best_val <= prev_val;
        best_idx <= prev_idx;
      end else if (CELL_INDEX == 0 || sum > prev_val) begin
        best_val <= sum;
        best_idx <= K_IDX;
      end else begin
        best_val <= prev_val;
        best_idx <= prev_idx;
      end
    end
  end

endmodule

`default_nettype wire

@@ design/mpsk_correlator_demodulator.sv @@
`default_nettype none

// Channel   Dir  Payload                              Handshake
// samples   in   sample (s16 Q1.15), symbol_strobe    valid/ready
// symbols   out  symbol (u4)                          valid/ready
// cfg       in   cfg_index, cfg_data (32)             cfg_we, no wait
//
// Items without a strobe are taken one per cycle: lookup and multiply in the
// accept cycle, accumulate in the next. A strobe item stops intake for the
// max search, which walks the cell chain from cell 0 upward. The search
// waits at its end while the previous symbol is still held in the output
// register. Reset clears the carrier phase, all sums and the registers
// (phase_step 0, symbol_bits 2).
module mpsk_correlator_demodulator import mcd_pkg::*; #(
  parameter int MAX_SYMBOLS    = MAX_SYMBOLS_DEF,
  parameter int COS_TABLE_BITS = COS_TABLE_BITS_DEF,
  parameter int SUM_BITS       = SUM_BITS_DEF
) (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  mcd_in_if.sink                      samples,
  mcd_out_if.source                   symbols
);

  localparam int IDX_BITS  = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
  localparam int MAX_LOG   = $clog2(MAX_SYMBOLS + 1) - 1;
  localparam int CNT_BITS  = $clog2(MAX_SYMBOLS + 1);
  localparam logic [CNT_BITS-1:0]   SCAN_LAST = CNT_BITS'(MAX_SYMBOLS);
  localparam logic [SYM_BITS_W-1:0] BITS_MAX  = SYM_BITS_W'(MAX_LOG);

  logic [PHASE_BITS-1:0]  phase_step;
  logic [SYM_BITS_W-1:0]  symbol_bits;
  logic [PHASE_BITS-1:0]  carrier_phase;
  logic [SYM_BITS_W-1:0]  eff_bits;

  mcd_state_t             state, state_next;
  logic [CNT_BITS-1:0]    scan_count, scan_count_next;
  logic                   pend_valid;
  logic                   pend_strobe;
  logic                   accept;
  logic                   load_out;
  cell_ctrl_t             ctrl;

  logic signed [SUM_BITS-1:0] prev_val [MAX_SYMBOLS];
  logic [IDX_BITS-1:0]        prev_idx [MAX_SYMBOLS];
  logic signed [SUM_BITS-1:0] tok_val  [MAX_SYMBOLS];
  logic [IDX_BITS-1:0]        tok_idx  [MAX_SYMBOLS];

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step  <= '0;
      symbol_bits <= SYM_BITS_W'(2);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PHASE_STEP:  phase_step  <= cfg_data;
        REG_SYMBOL_BITS: symbol_bits <= cfg_data[SYM_BITS_W-1:0];
        default: ;
      endcase
    end
  end

  // Bits per symbol limited to 1 .. log2(MAX_SYMBOLS)
  always_comb begin
    if (symbol_bits == '0) begin
      eff_bits = SYM_BITS_W'(1);
    end else if (symbol_bits > BITS_MAX) begin
      eff_bits = BITS_MAX;
    end else begin
      eff_bits = symbol_bits;
    end
  end

  // Intake: closed while a strobe item accumulates or the search runs
  assign samples.ready = (state == ST_RUN) && !(pend_valid && pend_strobe);
  assign accept        = samples.valid && samples.ready;
  assign load_out      = (state == ST_SCAN) && (scan_count == SCAN_LAST) &&
                         (!symbols.valid || symbols.ready);

  // Carrier phase advances after use
  always_ff @(posedge clk) begin
    if (rst) begin
      carrier_phase <= '0;
    end else if (accept) begin
      carrier_phase <= carrier_phase + phase_step;
    end
  end

  // Accumulate stage marker
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid  <= 1'b0;
      pend_strobe <= 1'b0;
    end else begin
      pend_valid  <= accept;
      pend_strobe <= accept && samples.symbol_strobe;
    end
  end

  // Sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_RUN;
      scan_count <= '0;
    end else begin
      state      <= state_next;
      scan_count <= scan_count_next;
    end
  end

  always_comb begin
    state_next      = state;
    scan_count_next = scan_count;
    ctrl.mul_en     = accept;
    ctrl.acc_en     = pend_valid;
    ctrl.scan_en    = 1'b0;
    ctrl.clear      = load_out;
    ctrl.eff_bits   = eff_bits;
    unique case (state)
      ST_RUN: begin
        scan_count_next = '0;
        if (pend_valid && pend_strobe) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        ctrl.scan_en = 1'b1;
        if (scan_count != SCAN_LAST) begin
          scan_count_next = scan_count + 1'b1;
        end else if (load_out) begin
          state_next      = ST_RUN;
          scan_count_next = '0;
        end
      end
      default: begin
        state_next = ST_RUN;
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      symbols.valid <= 1'b0;
    end else if (load_out) begin
      symbols.valid <= 1'b1;
    end else if (symbols.ready) begin
      symbols.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      symbols.symbol <= SYMBOL_W'(tok_idx[MAX_SYMBOLS-1]);
    end
  end

  // Cell chain
  for (genvar k = 0; k < MAX_SYMBOLS; k++) begin : g_cell
    if (k == 0) begin : g_head
      assign prev_val[k] = '0;
      assign prev_idx[k] = '0;
    end else begin : g_link
      assign prev_val[k] = tok_val[k-1];
      assign prev_idx[k] = tok_idx[k-1];
    end

    mcd_cell #(
      .CELL_INDEX     (k),
      .COS_TABLE_BITS (COS_TABLE_BITS),
      .SUM_BITS       (SUM_BITS),
      .IDX_BITS       (IDX_BITS)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .sample    (samples.sample),
      .phase_top (carrier_phase[PHASE_BITS-1 -: COS_TABLE_BITS]),
      .prev_val  (prev_val[k]),
      .prev_idx  (prev_idx[k]),
      .best_val  (tok_val[k]),
      .best_idx  (tok_idx[k])
    );
  end

  // No item enters right behind a strobe item
  a_strobe_blocks: assert property (@(posedge clk) disable iff (rst)
    accept && samples.symbol_strobe |=> !samples.ready)
    else $error("item accepted behind a strobe item");

  // Phase moves only with an accepted item
  a_phase_hold: assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(carrier_phase))
    else $error("carrier phase moved without an item");

  // Finished search hands a symbol to the output and reopens intake
  a_scan_done: assert property (@(posedge clk) disable iff (rst)
    load_out |=> (state == ST_RUN) && symbols.valid)
    else $error("search end did not deliver a symbol");

  // Accumulation never overlaps the search
  a_no_acc_in_scan: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> !pend_valid && !accept)
    else $error("item activity during max search");

endmodule

`default_nettype wire

@@ verif/mpsk_correlator_demodulator_tb.sv @@
`timescale 1ns / 1ps

module mpsk_correlator_demodulator_tb;
  import mcd_pkg::*;

  localparam int     NUM_PHASES   = MAX_SYMBOLS_DEF;
  localparam int     LUT_BITS     = COS_TABLE_BITS_DEF;
  localparam int     LUT_SIZE     = 1 << LUT_BITS;
  localparam int     QW           = LUT_SIZE / 4;
  localparam int     DRAIN_CYCLES = NUM_PHASES + 8;
  localparam int     FULL_RUN     = 48;
  localparam longint SUM_MAX      = (longint'(1) <<< (SUM_BITS_DEF - 1)) - 1;
  localparam longint SUM_MIN      = -SUM_MAX - 1;
  localparam bit [63:0] QUARTER_TURN_Q30 = 64'd1686629713;

  typedef enum logic [1:0] {
    RDY_ALWAYS,
    RDY_MOSTLY,
    RDY_SPARSE,
    RDY_COIN
  } ready_mode_t;

  logic                   clk;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  mcd_in_if  samples ();
  mcd_out_if symbols ();

  mpsk_correlator_demodulator dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .samples   (samples),
    .symbols   (symbols)
  );

  // Predictor state
  logic signed [COS_BITS-1:0] cos_lut [LUT_SIZE];
  logic [PHASE_BITS-1:0]      carrier_phase_q;
  logic [PHASE_BITS-1:0]      phase_step_q;
  logic [SYM_BITS_W-1:0]      symbol_bits_q;
  longint                     corr_sums [NUM_PHASES];
  logic [SYMBOL_W-1:0]        expected_symbols [$];
  logic [SYMBOL_W-1:0]        expected_sym;
  int                         mismatch_count = 0;

  // Sender pacing
  int burst_left = 0;
  bit gaps_on    = 1'b1;

  // Receiver stall pattern
  logic [7:0]  ready_tick = '0;
  ready_mode_t ready_mode = RDY_ALWAYS;

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Rounded Q1.15 magnitude of cos(r/QW * pi/2), Taylor series in Q30
  function automatic int quarter_wave_q15(input int unsigned r);
    bit [63:0] x;
    bit [63:0] x2;
    bit [63:0] term;
    bit [63:0] mag;
    longint    total;
    int        k;
    x     = (QUARTER_TURN_Q30 * 64'(r)) >> (LUT_BITS - 2);
    x2    = (x * x) >> 30;
    term  = 64'd1 << 30;
    total = longint'(term);
    for (k = 1; k <= 10; k++) begin
      mag  = (term * x2) >> 30;
      mag  = mag / 64'((2 * k - 1) * (2 * k));
      term = mag;
      total = (k % 2 == 1) ? total - longint'(term) : total + longint'(term);
    end
    if (total < 0) total = 0;
    total = (total + 16384) >>> 15;
    if (total > 32767) total = 32767;
    return int'(total);
  endfunction

  // Out-of-range bit counts fold into 1..log2(NUM_PHASES)
  function automatic int unsigned eff_symbol_bits();
    int unsigned b;
    b = symbol_bits_q;
    if (b < 1) b = 1;
    while (b > 1 && (1 << b) > NUM_PHASES) b--;
    return b;
  endfunction

  // Accumulate one sample into every active phase sum; decide on a strobe
  function automatic void correlate_sample(input logic signed [SAMPLE_BITS-1:0] smp,
                                           input logic strobe);
    int unsigned           eff;
    int unsigned           best;
    int                    k;
    logic [PHASE_BITS-1:0] ph;
    longint                acc;
    eff = eff_symbol_bits();
    for (k = 0; k < (1 << eff); k++) begin
      ph  = carrier_phase_q + (32'(k) << (32 - eff));
      acc = corr_sums[k] + longint'(smp) * longint'(cos_lut[ph[31 -: LUT_BITS]]);
      if (acc > SUM_MAX) acc = SUM_MAX;
      else if (acc < SUM_MIN) acc = SUM_MIN;
      corr_sums[k] = acc;
    end
    carrier_phase_q = carrier_phase_q + phase_step_q;
    if (strobe) begin
      best = 0;
      for (k = 1; k < (1 << eff); k++) begin
        if (corr_sums[k] > corr_sums[best]) best = k;
      end
      expected_symbols.push_back(SYMBOL_W'(best));
      for (k = 0; k < NUM_PHASES; k++) corr_sums[k] = 0;
    end
  endfunction

  // Drive one item, honoring burst/gap pacing, and predict on acceptance
  task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] smp, input logic strobe);
    int gap;
    if (burst_left == 0) begin
      gap = (gaps_on && $urandom_range(0, 2) != 0) ? $urandom_range(1, 6) : 0;
      if (gap > 0) begin
        @(negedge clk);
        samples.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    @(negedge clk);
    samples.valid         <= 1'b1;
    samples.sample        <= smp;
    samples.symbol_strobe <= strobe;
    do @(posedge clk); while (samples.ready !== 1'b1);
    correlate_sample(smp, strobe);
    burst_left--;
  endtask

  // Stop sending and wait until every decision is out and the pipe is empty
  task automatic quiesce();
    @(negedge clk);
    samples.valid <= 1'b0;
    while (expected_symbols.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    burst_left = 0;
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
    if (idx == REG_PHASE_STEP) phase_step_q = data;
    else symbol_bits_q = data[SYM_BITS_W-1:0];
  endtask

  // Reset values, carrier phase held at zero, all-zero tie
  task automatic test_defaults();
    send_sample(16'sd32767, 1'b1);
    send_sample(-16'sd32768, 1'b1);
    send_sample(16'sd0, 1'b1);
  endtask

  // Eighth-turn carrier phase gives equal sums on mirrored phases
  task automatic test_ties();
    quiesce();
    write_reg(REG_PHASE_STEP, 32'h2000_0000);
    send_sample(16'sd0, 1'b0);
    send_sample(16'sd1000, 1'b1);
    send_sample(-16'sd1000, 1'b1);
  endtask

  // Bit counts 0, 5, 7, 3, 4 and 1, including zero and values past the maximum
  task automatic test_symbol_bits_range();
    logic [SYM_BITS_W-1:0] bit_list [6];
    int                    i;
    bit_list = '{3'd0, 3'd5, 3'd7, 3'd3, 3'd4, 3'd1};
    quiesce();
    write_reg(REG_PHASE_STEP, 32'h1234_5678);
    for (i = 0; i < 6; i++) begin
      quiesce();
      write_reg(REG_SYMBOL_BITS, {29'd0, bit_list[i]});
      send_sample(-16'sd32768, 1'b0);
      send_sample(16'(int'($urandom_range(0, 65535))), 1'b1);
    end
  endtask

  // Largest step: phase moves back by one LSB per sample, wrapping modulo 2^32
  task automatic test_phase_wrap();
    quiesce();
    write_reg(REG_PHASE_STEP, 32'hFFFF_FFFF);
    write_reg(REG_SYMBOL_BITS, 32'd4);
    send_sample(-16'sd32768, 1'b0);
    send_sample(16'sd32767, 1'b0);
    send_sample(16'sd1, 1'b0);
    send_sample(-16'sd1, 1'b1);
  endtask

  // Back-to-back full-scale runs of both signs at carrier phase zero
  task automatic test_full_scale();
    quiesce();
    write_reg(REG_PHASE_STEP, 32'd0 - carrier_phase_q);
    write_reg(REG_SYMBOL_BITS, 32'd2);
    send_sample(16'sd0, 1'b0);
    quiesce();
    write_reg(REG_PHASE_STEP, 32'd0);
    gaps_on = 1'b0;
    repeat (FULL_RUN) send_sample(16'sd32767, 1'b0);
    send_sample(16'sd32767, 1'b1);
    repeat (FULL_RUN) send_sample(-16'sd32768, 1'b0);
    send_sample(-16'sd32768, 1'b1);
    gaps_on = 1'b1;
  endtask

  // Modulated symbols with noise, plus raw noise and broken framing
  task automatic test_random();
    logic [PHASE_BITS-1:0] step;
    logic [PHASE_BITS-1:0] ph;
    int                    p;
    int                    sent;
    int                    n;
    int                    len;
    int                    kind;
    int                    sym;
    int                    amp;
    int                    nz;
    int                    s;
    logic                  strobe;
    for (p = 0; p < 8; p++) begin
      quiesce();
      case (p % 5)
        0: step = 32'd0;
        1: step = 32'hFFFF_FFFF;
        2: step = 32'h8000_0000;
        3: step = 32'($urandom_range(32'h0400_0000, 32'h2000_0000));
        default: step = 32'($urandom);
      endcase
      write_reg(REG_PHASE_STEP, step);
      write_reg(REG_SYMBOL_BITS, {29'($urandom), 3'(p)});
      sent = 0;
      while (sent < 250) begin
        kind = $urandom_range(0, 19);
        len  = (kind == 0) ? 1 : (kind == 1) ? $urandom_range(30, 60) : $urandom_range(4, 16);
        sym  = $urandom_range(0, (1 << eff_symbol_bits()) - 1);
        amp  = ($urandom_range(0, 3) == 0) ? 32767 : $urandom_range(0, 32767);
        case ($urandom_range(0, 2))
          0: nz = 0;
          1: nz = 300;
          default: nz = 6000;
        endcase
        for (n = 0; n < len; n++) begin
          if (kind >= 17) begin
            s = int'($urandom_range(0, 65535)) - 32768;
          end else begin
            ph = carrier_phase_q + (32'(sym) << (32 - eff_symbol_bits()));
            s  = ((amp * int'(cos_lut[ph[31 -: LUT_BITS]])) >>> 15)
                 + int'($urandom_range(0, 2 * nz)) - nz;
            if (s > 32767) s = 32767;
            else if (s < -32768) s = -32768;
          end
          strobe = ((n == len - 1) && !(kind == 1 && $urandom_range(0, 1) == 0))
                   || ($urandom_range(0, 63) == 0);
          send_sample(16'(s), strobe);
          sent++;
        end
      end
    end
  endtask

  // Receiver stall pattern, switching to a random style whenever ready_tick[6:0] is zero
  always @(negedge clk) begin
    ready_tick <= ready_tick + 8'd1;
    if (ready_tick[6:0] == 7'd0) ready_mode <= ready_mode_t'($urandom_range(0, 3));
    case (ready_mode)
      RDY_ALWAYS: symbols.ready <= 1'b1;
      RDY_MOSTLY: symbols.ready <= ($urandom_range(0, 3) != 0);
      RDY_SPARSE: symbols.ready <= (ready_tick[2:0] == 3'd0);
      default:    symbols.ready <= ($urandom_range(0, 1) == 1);
    endcase
  end

  // Compare each decision with the oldest prediction
  always @(posedge clk) begin
    if (!rst && symbols.valid === 1'b1 && symbols.ready === 1'b1) begin
      if (expected_symbols.size() == 0) begin
        $error("symbol: unexpected item, actual %0d", symbols.symbol);
        mismatch_count++;
      end else begin
        expected_sym = expected_symbols.pop_front();
        if (symbols.symbol !== expected_sym) begin
          $error("symbol mismatch: expected %0d, actual %0d", expected_sym, symbols.symbol);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    int i;
    int quad;
    int r;
    int mag;
    rst                   = 1'b1;
    cfg_we                = 1'b0;
    cfg_index             = REG_PHASE_STEP;
    cfg_data              = '0;
    samples.valid         = 1'b0;
    samples.sample        = '0;
    samples.symbol_strobe = 1'b0;
    symbols.ready         = 1'b0;

    // Cosine table by quarter-wave symmetry
    for (i = 0; i < LUT_SIZE; i++) begin
      quad = i / QW;
      r    = i % QW;
      mag  = quarter_wave_q15((quad == 1 || quad == 3) ? QW - r : r);
      cos_lut[i] = (quad == 1 || quad == 2) ? 16'(-mag) : 16'(mag);
    end
    carrier_phase_q = '0;
    phase_step_q    = '0;
    symbol_bits_q   = 3'd2;
    for (i = 0; i < NUM_PHASES; i++) corr_sums[i] = 0;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_defaults();
    test_ties();
    test_symbol_bits_range();
    test_phase_wrap();
    test_full_scale();
    test_random();
    quiesce();

    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #48_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

@@ filelist.f @@
design/mcd_pkg.sv
design/mcd_in_if.sv
design/mcd_out_if.sv
design/mcd_cell.sv
design/mpsk_correlator_demodulator.sv
verif/mpsk_correlator_demodulator_tb.sv
